// ===== sv/eka_pkg.sv =====
// Package for the expiring keyed accumulator: widths, opcodes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package eka_pkg;
    localparam int TableEntriesDefault = 16;
    localparam int MaxResults = 16;
    localparam logic [31:0] ExpireReset = 32'd30;
    localparam logic OpInsert = 1'b0;
    localparam logic OpReport = 1'b1;
    localparam int InWidth = 96;   // key, amount, now
    localparam int OutWidth = 136; // key, total, seen, sum

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_FREE,
        ST_WRITE,
        ST_ACK,
        ST_SCAN,
        ST_PICK,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // Ranking compare: true when (ta,ka) goes before (tb,kb).
    function automatic logic ranks_before(input logic signed [31:0] ta,
                                          input logic signed [31:0] ka,
                                          input logic signed [31:0] tb,
                                          input logic signed [31:0] kb);
        logic r;
        begin
            if (ta != tb)
            begin
                r = ta > tb;
            end
            else
            begin
                r = ka < kb;
            end
            return r;
        end
    endfunction
endpackage

// ===== sv/expiring_keyed_accumulator_ranked.sv =====
// Top level of the expiring keyed accumulator with ranked report.
// Depends on eka_pkg and eka_table.
`timescale 1ns / 1ps
//  Channel  | Direction | Contents
//  s_axis   | in        | tuser=opcode, tdata={now,amount,key}
//  m_axis   | out       | tuser={dropped,valid}, tdata={sum,seen,total,key}, tlast
//  cfg      | in        | cfg_we/cfg_wdata write expire_seconds
// An insert runs a key scan, a free-slot scan on a miss, then a write unless full.
// A report first sums the live entries in one full scan; then each emitted
// rank is found by a full scan through the one shared compare unit.
// Reset is asynchronous: valid bits clear at once, no clearing pass.
// Output stalls hold the sequencer; no input is taken until the item finishes.
module expiring_keyed_accumulator_ranked #(
    parameter int TABLE_ENTRIES = eka_pkg::TableEntriesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [eka_pkg::InWidth-1:0] s_axis_tdata,  // key_id, amount, now_seconds
    input  logic        s_axis_tuser,                  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [eka_pkg::OutWidth-1:0] m_axis_tdata, // entry_key, entry_total,
                                                       // entry_seen, pool_sum
    output logic [1:0]  m_axis_tuser,                  // entry_valid, insert_dropped
    output logic        m_axis_tlast,                  // last_item
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import eka_pkg::*;
    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CntW = $clog2(TABLE_ENTRIES + 1);
    localparam int RankW = (CntW > 5) ? CntW : 5;
    localparam logic [CntW-1:0] LastIdx = CntW'(TABLE_ENTRIES - 1);
    localparam logic [RankW-1:0] MaxRes = RankW'(MaxResults);

    state_t state_reg, state_next;
    logic [31:0] expire_reg;
    logic op_reg;
    logic signed [31:0] key_reg, amt_reg;
    logic [31:0] now_reg;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [IdxW-1:0] hit_reg;
    logic found_reg;
    logic signed [39:0] sum_reg;
    logic [RankW-1:0] emitted_reg;
    logic [RankW-1:0] live_reg;
    // Previous emitted rank bound and the best candidate below it.
    logic have_prev_reg;
    logic signed [31:0] prev_total_reg, prev_key_reg;
    logic signed [31:0] best_total_reg, best_key_reg;
    logic [31:0] best_seen_reg;
    logic best_ok_reg;
    logic drop_reg;

    logic rd_used;
    logic signed [31:0] rd_key, rd_total;
    logic [31:0] rd_seen;
    logic wr_en;
    logic signed [31:0] wr_total;
    logic live, below_prev, better;
    logic signed [32:0] add_wide;
    logic signed [31:0] sat_sum;
    logic accept_in, out_fire;

    eka_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
        .clk(clk), .rst_n(rst_n),
        .rd_idx(idx_reg[IdxW-1:0]),
        .rd_used(rd_used), .rd_key(rd_key), .rd_total(rd_total), .rd_seen(rd_seen),
        .wr_en(wr_en), .wr_idx(hit_reg),
        .wr_key(key_reg), .wr_total(wr_total), .wr_seen(now_reg)
    );

    // Shared compare unit on the slot under the scan index.
    assign live = rd_used && ((now_reg - rd_seen) <= expire_reg);
    assign below_prev = !have_prev_reg ||
        ranks_before(prev_total_reg, prev_key_reg, rd_total, rd_key);
    assign better = !best_ok_reg ||
        ranks_before(rd_total, rd_key, best_total_reg, best_key_reg);
    assign add_wide = 33'(rd_total) + 33'(amt_reg);
    always_comb
    begin
        if (add_wide > 33'sh0_7FFF_FFFF)
        begin
            sat_sum = 32'sh7FFF_FFFF;
        end
        else if (add_wide < -33'sh0_8000_0000)
        begin
            sat_sum = 32'sh8000_0000;
        end
        else
        begin
            sat_sum = add_wide[31:0];
        end
    end
    // Hit write uses the slot read at hit_reg (idx_reg points there in WRITE).
    assign wr_total = (found_reg && live) ? sat_sum : amt_reg;
    assign wr_en = (state_reg == ST_WRITE);

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept_in)
                begin
                    state_next = (s_axis_tuser == OpReport) ? ST_SCAN : ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (rd_used && rd_key == key_reg)
                begin
                    state_next = ST_WRITE;
                end
                else if (idx_reg == LastIdx)
                begin
                    state_next = ST_FREE;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FREE:
            begin
                if (!live)
                begin
                    state_next = ST_WRITE;
                end
                else if (idx_reg == LastIdx)
                begin
                    state_next = ST_ACK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_ACK;
            end
            ST_ACK:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LastIdx)
                begin
                    idx_next = '0;
                    state_next = ST_PICK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_PICK:
            begin
                if (idx_reg == LastIdx)
                begin
                    idx_next = '0;
                    state_next = (best_ok_reg || (live && below_prev)) ? ST_EMIT
                                                                        : ST_EMPTY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    state_next = m_axis_tlast ? ST_IDLE : ST_PICK;
                end
            end
            ST_EMPTY:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            expire_reg <= ExpireReset;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            if (cfg_we)
            begin
                expire_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            op_reg <= s_axis_tuser;
            key_reg <= s_axis_tdata[31:0];
            amt_reg <= s_axis_tdata[63:32];
            now_reg <= s_axis_tdata[95:64];
            found_reg <= 1'b0;
            drop_reg <= 1'b0;
            sum_reg <= '0;
            live_reg <= '0;
            emitted_reg <= '0;
            have_prev_reg <= 1'b0;
            best_ok_reg <= 1'b0;
        end
        unique case (state_reg)
            ST_FIND:
            begin
                hit_reg <= idx_reg[IdxW-1:0];
                if (rd_used && rd_key == key_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            ST_FREE:
            begin
                hit_reg <= idx_reg[IdxW-1:0];
                if (live && idx_reg == LastIdx)
                begin
                    drop_reg <= 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (live)
                begin
                    sum_reg <= sum_reg + 40'(rd_total);
                    live_reg <= live_reg + 1'b1;
                end
            end
            ST_PICK:
            begin
                if (live && below_prev && better)
                begin
                    best_ok_reg <= 1'b1;
                    best_total_reg <= rd_total;
                    best_key_reg <= rd_key;
                    best_seen_reg <= rd_seen;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    emitted_reg <= emitted_reg + 1'b1;
                    have_prev_reg <= 1'b1;
                    prev_total_reg <= best_total_reg;
                    prev_key_reg <= best_key_reg;
                    best_ok_reg <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result outputs.
    always_comb
    begin
        m_axis_tvalid = 1'b0;
        m_axis_tdata = '0;
        m_axis_tuser = '0;
        m_axis_tlast = 1'b0;
        unique case (state_reg)
            ST_ACK:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tuser = {drop_reg, 1'b0};
                m_axis_tlast = 1'b1;
            end
            ST_EMPTY:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast = 1'b1;
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tuser = 2'b01;
                m_axis_tdata = {sum_reg, best_seen_reg, best_total_reg, best_key_reg};
                m_axis_tlast = (emitted_reg + 1'b1 == live_reg) ||
                               (emitted_reg + 1'b1 == MaxRes);
            end
            default:
            begin
            end
        endcase
    end

    // Inputs are taken only when the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> state_reg != ST_IDLE)
        else $error("item accepted without starting work");
    // An insert ends with exactly one acknowledge marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACK) |-> m_axis_tlast && !m_axis_tuser[0])
        else $error("insert acknowledge malformed");
    // A table write happens only during an insert.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> op_reg == OpInsert && !drop_reg)
        else $error("table written outside an insert");
endmodule

// ===== sv/eka_table.sv =====
// Slot table storage, read at one sequencer-chosen index each cycle.
// Depends on eka_pkg.
`timescale 1ns / 1ps
module eka_table #(
    parameter int TABLE_ENTRIES = eka_pkg::TableEntriesDefault,
    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [IdxW-1:0]          rd_idx,
    output logic                     rd_used,
    output logic signed [31:0]       rd_key,
    output logic signed [31:0]       rd_total,
    output logic [31:0]              rd_seen,
    input  logic                     wr_en,
    input  logic [IdxW-1:0]          wr_idx,
    input  logic signed [31:0]       wr_key,
    input  logic signed [31:0]       wr_total,
    input  logic [31:0]              wr_seen
);
    import eka_pkg::*;

    logic [TABLE_ENTRIES-1:0] used_reg;
    logic signed [31:0] key_mem [TABLE_ENTRIES];
    logic signed [31:0] total_mem [TABLE_ENTRIES];
    logic [31:0] seen_mem [TABLE_ENTRIES];

    // Valid bits clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (wr_en)
        begin
            used_reg[wr_idx] <= 1'b1;
        end
    end

    // Payload writes.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx] <= wr_key;
            total_mem[wr_idx] <= wr_total;
            seen_mem[wr_idx] <= wr_seen;
        end
    end

    // Asynchronous read of the small register file at the scan index.
    assign rd_used = used_reg[rd_idx];
    assign rd_key = key_mem[rd_idx];
    assign rd_total = total_mem[rd_idx];
    assign rd_seen = seen_mem[rd_idx];
endmodule

// ===== bench/eka_checker.sv =====
// Checker for the expiring keyed accumulator: watches the input and output
// channels and the register write port, predicts each result and compares.
// Depends on eka_pkg for widths and opcodes.
`timescale 1ns / 1ps
module eka_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [eka_pkg::InWidth-1:0]  s_axis_tdata,
    input  logic                         s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [eka_pkg::OutWidth-1:0] m_axis_tdata,
    input  logic [1:0]                   m_axis_tuser,
    input  logic                         m_axis_tlast,
    input  logic                         cfg_we,
    input  logic [31:0]                  cfg_wdata,
    output int                           fail_count,
    output int                           pending
);
    import eka_pkg::*;

    localparam int Slots = TableEntriesDefault;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] key;
        logic signed [31:0] total;
        logic [31:0]        seen;
        logic signed [39:0] sum;
        logic               dropped;
        logic               last;
    } ranked_entry_t;

    // Shadow copy of the table and the expiry register.
    logic               tbl_used [Slots];
    logic signed [31:0] tbl_key [Slots];
    logic signed [31:0] tbl_total [Slots];
    logic [31:0]        tbl_seen [Slots];
    logic [31:0]        expire_limit;

    ranked_entry_t expected_entries[$];

    function automatic logic stale(int i, logic [31:0] now);
        logic [31:0] idle;
        begin
            idle = now - tbl_seen[i];
            return idle > expire_limit;
        end
    endfunction

    function automatic logic signed [31:0] clamp_add(logic signed [31:0] a,
                                                    logic signed [31:0] b);
        logic signed [32:0] s;
        begin
            s = 33'(a) + 33'(b);
            if (s > 33'sd2147483647)
            begin
                return 32'sh7fffffff;
            end
            if (s < -33'sd2147483648)
            begin
                return 32'sh80000000;
            end
            return s[31:0];
        end
    endfunction

    function automatic logic goes_first(int a, int b);
        begin
            if (tbl_total[a] != tbl_total[b])
            begin
                return tbl_total[a] > tbl_total[b];
            end
            return tbl_key[a] < tbl_key[b];
        end
    endfunction

    // Append one predicted result at the tail of the expected queue.
    task automatic queue_result(ranked_entry_t item);
        begin
            expected_entries = {expected_entries, item};
        end
    endtask

    // Apply one accepted transaction to the shadow table and queue its results.
    task automatic accumulate_and_rank(logic op, logic signed [31:0] key,
                                       logic signed [31:0] amt, logic [31:0] now);
        ranked_entry_t r;
        int order[Slots];
        int n;
        int j;
        int pick;
        int emit;
        logic signed [39:0] sum;
        logic found;
        begin
            r = '0;
            r.last = 1'b1;
            n = 0;
            sum = '0;
            found = 1'b0;
            pick = -1;
            if (op == OpInsert)
            begin
                for (int i = 0; i < Slots; i++)
                begin
                    if (!found && tbl_used[i] && tbl_key[i] == key)
                    begin
                        tbl_total[i] = stale(i, now) ? amt : clamp_add(tbl_total[i], amt);
                        tbl_seen[i] = now;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    for (int i = 0; i < Slots; i++)
                    begin
                        if (pick < 0 && (!tbl_used[i] || stale(i, now)))
                        begin
                            pick = i;
                        end
                    end
                    if (pick < 0)
                    begin
                        r.dropped = 1'b1;
                    end
                    else
                    begin
                        tbl_used[pick] = 1'b1;
                        tbl_key[pick] = key;
                        tbl_total[pick] = amt;
                        tbl_seen[pick] = now;
                    end
                end
                queue_result(r);
            end
            else
            begin
                for (int i = 0; i < Slots; i++)
                begin
                    if (tbl_used[i] && !stale(i, now))
                    begin
                        sum += 40'(tbl_total[i]);
                        j = n;
                        while (j > 0 && goes_first(i, order[j - 1]))
                        begin
                            order[j] = order[j - 1];
                            j--;
                        end
                        order[j] = i;
                        n++;
                    end
                end
                if (n == 0)
                begin
                    queue_result(r);
                end
                else
                begin
                    emit = n > MaxResults ? MaxResults : n;
                    for (int k = 0; k < emit; k++)
                    begin
                        r.hit = 1'b1;
                        r.key = tbl_key[order[k]];
                        r.total = tbl_total[order[k]];
                        r.seen = tbl_seen[order[k]];
                        r.sum = sum;
                        r.last = (k == emit - 1);
                        queue_result(r);
                    end
                end
            end
        end
    endtask

    assign pending = expected_entries.size();

    // Track inputs and compare outputs at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        ranked_entry_t got;
        ranked_entry_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < Slots; i++)
            begin
                tbl_used[i] = 1'b0;
                tbl_key[i] = '0;
                tbl_total[i] = '0;
                tbl_seen[i] = '0;
            end
            expire_limit = ExpireReset;
            expected_entries.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                expire_limit = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                accumulate_and_rank(s_axis_tuser, s_axis_tdata[31:0],
                                    s_axis_tdata[63:32], s_axis_tdata[95:64]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hit = m_axis_tuser[0];
                got.dropped = m_axis_tuser[1];
                got.key = m_axis_tdata[31:0];
                got.total = m_axis_tdata[63:32];
                got.seen = m_axis_tdata[95:64];
                got.sum = m_axis_tdata[135:96];
                got.last = m_axis_tlast;
                if (expected_entries.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: unexpected result %p", $realtime, got);
                    end
                end
                else
                begin
                    want = expected_entries.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, got);
                        end
                    end
                end
            end
        end
    end
endmodule

// ===== bench/expiring_keyed_accumulator_ranked_test.sv =====
// Testbench top for the expiring keyed accumulator: drives insert and report
// transactions and register writes, and gives the verdict from eka_checker.
// Depends on eka_pkg, eka_checker and the block itself.
`timescale 1ns / 1ps
module expiring_keyed_accumulator_ranked_test;
    import eka_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [InWidth-1:0]    s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OutWidth-1:0]   m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [31:0]           cfg_wdata = '0;
    int                    fail_count;
    int                    pending;
    logic [31:0]           clock_now = 32'd0;
    int                    hold_off_cycles = 0;

    always #4 clk = ~clk;

    expiring_keyed_accumulator_ranked dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    eka_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_length();
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                return $urandom_range(20, 80);
            end
            return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
        end
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // Offer one transaction and wait until it is accepted, then leave a gap.
    task automatic offer(logic op, logic [31:0] key, logic [31:0] amt, logic [31:0] now,
                         int gap);
        begin
            s_axis_tuser <= op;
            s_axis_tdata <= {now, amt, key};
            s_axis_tvalid <= 1'b1;
            @(posedge clk);
            while (!s_axis_tready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Wait for all results, let the block settle, then write the register.
    task automatic set_expiry(logic [31:0] value);
        begin
            s_axis_tvalid <= 1'b0;
            while (pending != 0)
            begin
                @(negedge clk);
            end
            repeat (60) @(negedge clk);
            cfg_wdata <= value;
            cfg_we <= 1'b1;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Random key from a small pool so that keys repeat, with occasional wide keys.
    function automatic logic [31:0] pick_key();
        begin
            case ($urandom_range(0, 5))
                0: return $urandom();
                1: return 32'h8000_0000 + $urandom_range(0, 3);
                2: return 32'h7fff_fffc + $urandom_range(0, 3);
                default: return $urandom_range(0, 23) - 8;
            endcase
        end
    endfunction

    function automatic logic [31:0] pick_amount();
        begin
            case ($urandom_range(0, 5))
                0: return $urandom();
                1: return 32'h7fff_ff00 + $urandom_range(0, 255);
                2: return 32'h8000_0000 + $urandom_range(0, 255);
                default: return $urandom_range(0, 200) - 100;
            endcase
        end
    endfunction

    task automatic random_phase(int count, int max_step);
        begin
            for (int i = 0; i < count; i++)
            begin
                clock_now = clock_now + $urandom_range(0, max_step);
                if ($urandom_range(0, 9) < 2)
                begin
                    offer(OpReport, $urandom(), $urandom(), clock_now, gap_length());
                end
                else
                begin
                    offer(OpInsert, pick_key(), pick_amount(), clock_now, gap_length());
                end
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty report, extremes, saturation both ways, ties.
        offer(OpReport, 32'd0, 32'd0, 32'd0, 0);
        offer(OpInsert, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 1);
        offer(OpInsert, 32'h8000_0000, 32'd5, 32'd1, 0);
        offer(OpInsert, 32'h7fff_ffff, 32'h8000_0000, 32'd2, 0);
        offer(OpInsert, 32'h7fff_ffff, 32'hffff_ffff, 32'd3, 0);
        offer(OpInsert, 32'd7, 32'd10, 32'd4, 0);
        offer(OpInsert, 32'd3, 32'd10, 32'd4, 0);
        offer(OpReport, 32'hffff_ffff, 32'hffff_ffff, 32'd5, 2);
        // Expiry restarts a total: idle 31 exceeds the reset limit.
        offer(OpInsert, 32'd7, 32'd1, 32'd35, 0);
        offer(OpReport, 32'd0, 32'd0, 32'd35, 0);
        // Fill the table, then an insert gets dropped, then time wrap.
        for (int i = 0; i < 16; i++)
        begin
            offer(OpInsert, 32'd100 + i, i, 32'd36, 0);
        end
        offer(OpInsert, 32'd999, 32'd1, 32'd37, 0);
        offer(OpReport, 32'd0, 32'd0, 32'hffff_ffff, 0);

        // Receiver holds off long while the sender keeps offering.
        hold_off_cycles <= 400;
        clock_now = 32'hffff_fff0;
        random_phase(40, 2);

        // Sender pauses until everything has come back.
        while (pending != 0)
        begin
            @(negedge clk);
        end
        random_phase(80, 3);

        set_expiry(32'd0);
        random_phase(60, 1);
        set_expiry(32'hffff_ffff);
        random_phase(80, 50);
        set_expiry(32'd5);
        random_phase(80, 4);
        set_expiry(32'd30);
        random_phase(60, 10);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("** expiring_keyed_accumulator_ranked: PASSED **");
        end
        else
        begin
            $display("** expiring_keyed_accumulator_ranked: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #8_000_000;
        $display("** expiring_keyed_accumulator_ranked: FAILED **");
        $finish;
    end
endmodule
